FILE: design/dwpi_pkg.sv
// ----------------------------------------------------------------------------
// dwpi_pkg
// Shared types and constants for the dual wheel PI speed controller.
// ----------------------------------------------------------------------------
package dwpi_pkg;

   localparam logic [19:0] US_PER_S = 20'd1000000;

   localparam logic [1:0] CSR_MM_PER_TICK    = 2'd0;
   localparam logic [1:0] CSR_PROP_GAIN      = 2'd1;
   localparam logic [1:0] CSR_INTEG_GAIN     = 2'd2;
   localparam logic [1:0] CSR_INTEGRAL_BOUND = 2'd3;

   typedef struct packed {
      logic [19:0] mm_per_tick;
      logic [23:0] prop_gain;
      logic [23:0] integ_gain;
      logic [29:0] integral_bound;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic read_op;
   } lane_ctl_type;

   typedef struct packed {
      logic               done;
      logic signed [15:0] drive;
      logic signed [31:0] distance;
   } lane_stat_type;

endpackage

FILE: design/dwpi_lane.sv
// ----------------------------------------------------------------------------
// dwpi_lane
// One wheel: distance counter, speed by serial division, PI update.
// ----------------------------------------------------------------------------
module dwpi_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  dwpi_pkg::cfg_type      cfg,
   input  dwpi_pkg::lane_ctl_type ctl,
   input  logic signed [15:0]    ticks,
   input  logic signed [20:0]    target,
   input  logic [19:0]           elapsed,
   output dwpi_pkg::lane_stat_type stat
);

   typedef enum logic [3:0] {
      L_IDLE, L_MUL_A, L_MUL_B, L_SUM, L_DIV, L_SPEED,
      L_INTEG, L_PROD, L_TOTAL, L_SAT
   } lane_state_type;

   lane_state_type     state_ff;
   logic signed [15:0] ticks_ff;
   logic signed [20:0] target_ff;
   logic [19:0]        elapsed_ff;
   logic [35:0]        prod_a_ff;
   logic [37:0]        pp_lo_ff;
   logic [37:0]        pp_hi_ff;
   logic [47:0]        dividend_ff;
   logic [20:0]        rem_ff;
   logic [47:0]        quot_ff;
   logic [5:0]         cnt_ff;
   logic signed [32:0] err_ff;
   logic signed [31:0] integ_ff;
   logic signed [57:0] p_prod_ff;
   logic signed [56:0] i_prod_ff;
   logic signed [49:0] q_ff;
   logic signed [15:0] drive_ff;
   logic [31:0]        dist_ff;
   logic [31:0]        dist_out_ff;
   logic               done_ff;

   logic [15:0]        tick_mag;
   logic [55:0]        magn;
   logic [21:0]        rem_sh;
   logic               rem_ge;
   logic [20:0]        rem_in;
   logic signed [31:0] speed;
   logic signed [33:0] sum;
   logic signed [33:0] bnd;
   logic               sum_ok;
   logic signed [58:0] total;
   logic signed [58:0] total_rnd;

   always_comb begin
      tick_mag = ticks_ff[15] ? 16'(-ticks_ff) : 16'(ticks_ff);
      magn     = {18'd0, pp_lo_ff} + {pp_hi_ff, 18'd0};
      rem_sh   = {rem_ff, dividend_ff[47]};
      rem_ge   = rem_sh >= {2'b00, elapsed_ff};
      rem_in   = rem_ge ? 21'(rem_sh - {2'b00, elapsed_ff}) : rem_sh[20:0];
      if (!ticks_ff[15]) begin
         speed = (quot_ff > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quot_ff[31:0]);
      end else begin
         speed = (quot_ff > 48'h8000_0000) ? 32'sh8000_0000 : $signed(-quot_ff[31:0]);
      end
      sum    = {{2{integ_ff[31]}}, integ_ff} + {err_ff[32], err_ff};
      bnd    = $signed({4'd0, cfg.integral_bound});
      sum_ok = (sum > -bnd) && (sum < bnd);
      total  = 59'sd0 - {p_prod_ff[57], p_prod_ff} - {{2{i_prod_ff[56]}}, i_prod_ff};
      // truncate toward zero on the divide by 512
      total_rnd = total + (total[58] ? 59'sd511 : 59'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= L_IDLE;
         integ_ff    <= '0;
         dist_ff     <= '0;
         dist_out_ff <= '0;
         drive_ff    <= '0;
         done_ff     <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            L_IDLE: begin
               if (ctl.start) begin
                  if (ctl.read_op) begin
                     dist_out_ff <= dist_ff;
                     dist_ff     <= '0;
                     done_ff     <= 1'b1;
                  end else begin
                     ticks_ff   <= ticks;
                     target_ff  <= target;
                     elapsed_ff <= (elapsed == 20'd0) ? 20'd1 : elapsed;
                     dist_ff    <= dist_ff + 32'(ticks);
                     state_ff   <= L_MUL_A;
                  end
               end
            end
            L_MUL_A: begin
               prod_a_ff <= 36'(tick_mag) * 36'(cfg.mm_per_tick);
               state_ff  <= L_MUL_B;
            end
            L_MUL_B: begin
               pp_lo_ff <= 38'(prod_a_ff[17:0]) * 38'(dwpi_pkg::US_PER_S);
               pp_hi_ff <= 38'(prod_a_ff[35:18]) * 38'(dwpi_pkg::US_PER_S);
               state_ff <= L_SUM;
            end
            L_SUM: begin
               // the divide by 256 is exact to do first
               dividend_ff <= magn[55:8];
               rem_ff      <= '0;
               quot_ff     <= '0;
               cnt_ff      <= 6'd47;
               state_ff    <= L_DIV;
            end
            L_DIV: begin
               rem_ff      <= rem_in;
               quot_ff     <= {quot_ff[46:0], rem_ge};
               dividend_ff <= {dividend_ff[46:0], 1'b0};
               cnt_ff      <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd0) begin
                  state_ff <= L_SPEED;
               end
            end
            L_SPEED: begin
               err_ff   <= {speed[31], speed} - {{12{target_ff[20]}}, target_ff};
               state_ff <= L_INTEG;
            end
            L_INTEG: begin
               if (sum_ok) begin
                  integ_ff <= sum[31:0];
               end
               state_ff <= L_PROD;
            end
            L_PROD: begin
               p_prod_ff <= $signed({1'b0, cfg.prop_gain}) * err_ff;
               i_prod_ff <= $signed({1'b0, cfg.integ_gain}) * integ_ff;
               state_ff  <= L_TOTAL;
            end
            L_TOTAL: begin
               q_ff     <= total_rnd[58:9];
               state_ff <= L_SAT;
            end
            L_SAT: begin
               if (q_ff > 50'sd32767) begin
                  drive_ff <= 16'sd32767;
               end else if (q_ff < -50'sd32767) begin
                  drive_ff <= -16'sd32767;
               end else begin
                  drive_ff <= q_ff[15:0];
               end
               dist_out_ff <= dist_ff;
               done_ff     <= 1'b1;
               state_ff    <= L_IDLE;
            end
            default: begin
               state_ff <= L_IDLE;
            end
         endcase
      end
   end

   assign stat.done     = done_ff;
   assign stat.drive    = drive_ff;
   assign stat.distance = dist_out_ff;

endmodule

FILE: design/dwpi_merge.sv
// ----------------------------------------------------------------------------
// dwpi_merge
// Combine lane results into one result item and hold it for the sink.
// ----------------------------------------------------------------------------
module dwpi_merge #(
   parameter int WHEEL_COUNT = 2
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load,
   input  dwpi_pkg::lane_stat_type [WHEEL_COUNT-1:0] stat,
   input  logic                                     rsp_tready,
   output logic                                     rsp_tvalid,
   output logic [95:0]                              rsp_tdata
);

   localparam int RIGHT_IDX = (WHEEL_COUNT > 1) ? 1 : 0;

   logic               valid_ff;
   logic [95:0]        data_ff;
   logic [95:0]        data_in;
   logic signed [15:0] right_drive;
   logic signed [31:0] right_dist;

   always_comb begin
      right_drive = (WHEEL_COUNT > 1) ? stat[RIGHT_IDX].drive : 16'sd0;
      right_dist  = (WHEEL_COUNT > 1) ? stat[RIGHT_IDX].distance : 32'sd0;
      data_in     = {right_dist, stat[0].distance, right_drive, stat[0].drive};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

FILE: design/dual_wheel_pi_speed_controller_unit.sv
// ----------------------------------------------------------------------------
// dual_wheel_pi_speed_controller_unit
// Multi-wheel PI speed loop with conditional integration, one lane per wheel.
// ----------------------------------------------------------------------------
// Channel | Dir | Signals                          | Content
// req     | in  | req_tvalid/tready/tdata/tuser    | control or read item
// rsp     | out | rsp_tvalid/tready/tdata          | drives and distances
// csr     | in  | csr_we/csr_index/csr_wdata       | register writes
//
// A control item runs each lane through multiply, sum, the 48-step restoring
// divider, PI update and saturation; a read item skips them.
// All lanes run in lockstep; one item is in flight at a time.
// Reset clears integrals, distances, last drives and loads register defaults.
// The result sits in an output register, so the next item is accepted while
// the sink stalls; a finished lane result waits if that register is full.
// ----------------------------------------------------------------------------
module dual_wheel_pi_speed_controller_unit #(
   parameter int WHEEL_COUNT = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] left_ticks, [31:16] right_ticks, [51:32] elapsed_us,
   // [72:52] left_target, [93:73] right_target, [95:94] zero
   input  logic [95:0] req_tdata,
   // [0] opcode
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] left_drive, [31:16] right_drive, [63:32] left_odometer,
   // [95:64] right_odometer
   output logic [95:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [29:0] csr_wdata
);

   dwpi_pkg::cfg_type                        cfg_ff;
   dwpi_pkg::lane_ctl_type                   lane_ctl;
   dwpi_pkg::lane_stat_type [WHEEL_COUNT-1:0] stat;
   logic [WHEEL_COUNT-1:0]                   done_vec;
   logic                                     busy_ff;
   logic                                     pending_ff;
   logic                                     accept;
   logic                                     all_done;
   logic                                     load;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mm_per_tick    <= 20'd65536;
         cfg_ff.prop_gain      <= '0;
         cfg_ff.integ_gain     <= '0;
         cfg_ff.integral_bound <= 30'd1048576;
      end else if (csr_we) begin
         case (csr_index)
            dwpi_pkg::CSR_MM_PER_TICK:    cfg_ff.mm_per_tick    <= csr_wdata[19:0];
            dwpi_pkg::CSR_PROP_GAIN:      cfg_ff.prop_gain      <= csr_wdata[23:0];
            dwpi_pkg::CSR_INTEG_GAIN:     cfg_ff.integ_gain     <= csr_wdata[23:0];
            dwpi_pkg::CSR_INTEGRAL_BOUND: cfg_ff.integral_bound <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // take an item only when lanes are free and no finished result waits
   assign req_tready       = !busy_ff && !pending_ff;
   assign accept           = req_tvalid && req_tready;
   assign lane_ctl.start   = accept;
   assign lane_ctl.read_op = req_tuser;
   assign all_done         = &done_vec;
   // move the lane results out when the output register is free
   assign load             = pending_ff && (!rsp_tvalid || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (all_done) begin
            busy_ff <= 1'b0;
         end
         if (all_done) begin
            pending_ff <= 1'b1;
         end else if (load) begin
            pending_ff <= 1'b0;
         end
      end
   end

   // one lane per wheel; wheels past the second see no ticks and no target
   for (genvar i = 0; i < WHEEL_COUNT; i++) begin : g_lane
      logic signed [15:0] lane_ticks;
      logic signed [20:0] lane_target;

      if (i == 0) begin : g_left
         assign lane_ticks  = req_tdata[15:0];
         assign lane_target = req_tdata[72:52];
      end else if (i == 1) begin : g_right
         assign lane_ticks  = req_tdata[31:16];
         assign lane_target = req_tdata[93:73];
      end else begin : g_extra
         assign lane_ticks  = '0;
         assign lane_target = '0;
      end

      dwpi_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .cfg     (cfg_ff),
         .ctl     (lane_ctl),
         .ticks   (lane_ticks),
         .target  (lane_target),
         .elapsed (req_tdata[51:32]),
         .stat    (stat[i])
      );

      assign done_vec[i] = stat[i].done;
   end

   dwpi_merge #(
      .WHEEL_COUNT (WHEEL_COUNT)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // lanes run in lockstep, so they finish together
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      $countones(done_vec) == 0 || all_done)
      else $error("lanes finished out of step");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted item did not start lanes");

   a_busy_pending: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && pending_ff))
      else $error("new work while a result waits");

   a_done_only_busy: assert property (@(posedge clock) disable iff (reset)
      all_done |-> busy_ff)
      else $error("lane result with no item in flight");

endmodule
